>>> src/mcpd_pkg.sv
// ----------------------------------------------------------------------------
// Debouncer package
// Shared types and constants of the multi-channel pin debouncer.
// ----------------------------------------------------------------------------
package mcpd_pkg;

    localparam int SLOTS      = 4;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [TIME_W-1:0]    time_t;
    typedef logic [SLOTS-1:0]     level_vec_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_ENABLE        = 3'd0;
    localparam cfg_idx_t REG_FILTER_TIME_0 = 3'd1;
    localparam cfg_idx_t REG_FILTER_TIME_1 = 3'd2;
    localparam cfg_idx_t REG_FILTER_TIME_2 = 3'd3;
    localparam cfg_idx_t REG_FILTER_TIME_3 = 3'd4;

    typedef struct packed {
        logic cur;
        logic nxt;
        logic changed;
    } chan_status_t;

endpackage

>>> src/mcpd_cfg.sv
// ----------------------------------------------------------------------------
// Debouncer configuration registers
// Holds the channel enable mask and one filter time per slot.
// ----------------------------------------------------------------------------
module mcpd_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  mcpd_pkg::cfg_idx_t                  cfg_index,
    input  logic [mcpd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output mcpd_pkg::level_vec_t                enable,
    output mcpd_pkg::time_t                     filter_time [mcpd_pkg::SLOTS]
);

    mcpd_pkg::level_vec_t enable_reg;
    mcpd_pkg::time_t      filter_time_reg [mcpd_pkg::SLOTS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= '0;
            for (int i = 0; i < mcpd_pkg::SLOTS; i++) begin
                filter_time_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mcpd_pkg::REG_ENABLE: begin
                    enable_reg <= cfg_wdata[mcpd_pkg::SLOTS-1:0];
                end
                mcpd_pkg::REG_FILTER_TIME_0: begin
                    filter_time_reg[0] <= cfg_wdata[mcpd_pkg::TIME_W-1:0];
                end
                mcpd_pkg::REG_FILTER_TIME_1: begin
                    filter_time_reg[1] <= cfg_wdata[mcpd_pkg::TIME_W-1:0];
                end
                mcpd_pkg::REG_FILTER_TIME_2: begin
                    filter_time_reg[2] <= cfg_wdata[mcpd_pkg::TIME_W-1:0];
                end
                mcpd_pkg::REG_FILTER_TIME_3: begin
                    filter_time_reg[3] <= cfg_wdata[mcpd_pkg::TIME_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign enable      = enable_reg;
    assign filter_time = filter_time_reg;

endmodule

>>> src/mcpd_channel.sv
// ----------------------------------------------------------------------------
// Debouncer channel
// State and update logic of one filtered pin.
// ----------------------------------------------------------------------------
module mcpd_channel (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  logic                   enable,
    input  mcpd_pkg::time_t        filter_time,
    input  mcpd_pkg::time_t        now_ms,
    input  logic                   level,
    output mcpd_pkg::chan_status_t status
);

    logic            last_raw_reg;
    logic            last_raw_next;
    logic            debounced_reg;
    logic            debounced_next;
    mcpd_pkg::time_t stable_since_reg;
    mcpd_pkg::time_t stable_since_next;
    mcpd_pkg::time_t elapsed;
    logic            raw_moved;

    always_comb begin
        raw_moved         = level != last_raw_reg;
        stable_since_next = raw_moved ? now_ms : stable_since_reg;
        last_raw_next     = level;
        elapsed           = now_ms - stable_since_next;
        debounced_next    = debounced_reg;
        if (level != debounced_reg && elapsed >= filter_time) begin
            debounced_next = level;
        end
        if (!enable) begin
            last_raw_next     = 1'b0;
            debounced_next    = 1'b0;
            stable_since_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_reg     <= 1'b0;
            debounced_reg    <= 1'b0;
            stable_since_reg <= '0;
        end else if (step) begin
            last_raw_reg     <= last_raw_next;
            debounced_reg    <= debounced_next;
            stable_since_reg <= stable_since_next;
        end
    end

    assign status.cur     = debounced_reg;
    assign status.nxt     = debounced_next;
    assign status.changed = debounced_next != debounced_reg;

endmodule

>>> src/multi_channel_pin_debouncer.sv
// ----------------------------------------------------------------------------
// Multi-channel pin debouncer
// Filters up to four pins against per-channel stable times.
//
//   Channel   Ports                                        Direction
//   request   s_valid/s_ready, s_now_ms, s_raw_levels      in
//   result    m_valid/m_ready, m_filtered_levels,          out
//             m_changed_mask
//   config    cfg_wr_en, cfg_index, cfg_wdata              in
//
// One request per cycle is accepted while s_ready is high; its result passes
// through the input register and then the result register.
// Each channel needs one 32-bit subtract and compare on the request register.
// Reset clears all channel state and configuration registers.
// A stalled result holds the result register; one more request waits in the
// input register before s_ready drops.
// ----------------------------------------------------------------------------
module multi_channel_pin_debouncer #(
    parameter int CHANNELS = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [31:0]                     s_now_ms,
    input  logic [3:0]                      s_raw_levels,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [3:0]                      m_filtered_levels,
    output logic [3:0]                      m_changed_mask,
    input  logic                            cfg_wr_en,
    input  mcpd_pkg::cfg_idx_t              cfg_index,
    input  logic [mcpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    mcpd_pkg::level_vec_t   enable;
    mcpd_pkg::time_t        filter_time [mcpd_pkg::SLOTS];
    mcpd_pkg::chan_status_t status [mcpd_pkg::SLOTS];

    logic                 in_valid_reg;
    mcpd_pkg::time_t      in_now_reg;
    mcpd_pkg::level_vec_t in_raw_reg;
    logic                 out_valid_reg;
    mcpd_pkg::level_vec_t out_levels_reg;
    mcpd_pkg::level_vec_t out_changed_reg;
    mcpd_pkg::level_vec_t levels_next;
    mcpd_pkg::level_vec_t changed_next;
    mcpd_pkg::level_vec_t deb_cur;
    mcpd_pkg::level_vec_t active_mask;
    logic                 advance;

    mcpd_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .enable      (enable),
        .filter_time (filter_time)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    for (genvar i = 0; i < mcpd_pkg::SLOTS; i++) begin : g_chan
        if (i < CHANNELS) begin : g_on
            mcpd_channel u_channel (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .step        (advance),
                .enable      (enable[i]),
                .filter_time (filter_time[i]),
                .now_ms      (in_now_reg),
                .level       (in_raw_reg[i]),
                .status      (status[i])
            );
            assign active_mask[i] = enable[i];
        end else begin : g_off
            assign status[i]      = '0;
            assign active_mask[i] = 1'b0;
        end
        assign levels_next[i]  = status[i].nxt;
        assign changed_next[i] = status[i].changed;
        assign deb_cur[i]      = status[i].cur;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_now_reg <= s_now_ms;
            in_raw_reg <= s_raw_levels;
        end
        if (advance) begin
            out_levels_reg  <= levels_next;
            out_changed_reg <= changed_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_filtered_levels = out_levels_reg;
    assign m_changed_mask    = out_changed_reg;

    a_disabled_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_filtered_levels & ~active_mask) == '0)
        else $error("disabled channel shows a high filtered level");

    a_changed_match: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_changed_mask == (m_filtered_levels ^ $past(deb_cur)))
        else $error("changed mask does not match filtered level transition");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(deb_cur))
        else $error("channel state moved without a request");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("request side stalled without a full pipeline");

endmodule

>>> tb/sv/tb_multi_channel_pin_debouncer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pin debouncer testbench
// Drives timestamped pin samples through the debouncer under random
// configurations and random stalls on both channels. Each request is
// predicted per channel, and every result is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_multi_channel_pin_debouncer;

    localparam int NUM_CHANNELS = 4;
    localparam int STALL_LIMIT  = 1000;
    localparam int REPORT_MAX   = 10;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS  = 90;

    typedef struct packed {
        mcpd_pkg::time_t      now;
        mcpd_pkg::level_vec_t raw;
    } sample_t;

    typedef struct packed {
        mcpd_pkg::level_vec_t levels;
        mcpd_pkg::level_vec_t changed;
    } deb_result_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [31:0]                     s_now_ms = '0;
    logic [3:0]                      s_raw_levels = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [3:0]                      m_filtered_levels;
    logic [3:0]                      m_changed_mask;
    logic                            cfg_wr_en = 1'b0;
    mcpd_pkg::cfg_idx_t              cfg_index = mcpd_pkg::REG_ENABLE;
    logic [mcpd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    sample_t     samples_todo[$];
    deb_result_t levels_due[$];

    mcpd_pkg::level_vec_t cfg_enable = '0;
    mcpd_pkg::time_t      cfg_filter[mcpd_pkg::SLOTS] = '{default: '0};
    mcpd_pkg::level_vec_t seen_raw = '0;
    mcpd_pkg::level_vec_t deb_level = '0;
    mcpd_pkg::time_t      since_ms[mcpd_pkg::SLOTS] = '{default: '0};

    int          send_gap_max = 0;
    int          ready_gap_max = 0;
    int          send_gap = 0;
    int          ready_gap = 0;
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    sample_t     next_sample;
    deb_result_t want;
    deb_result_t predicted;
    logic        next_ready;

    multi_channel_pin_debouncer #(
        .CHANNELS(NUM_CHANNELS)
    ) i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_now_ms          (s_now_ms),
        .s_raw_levels      (s_raw_levels),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_filtered_levels (m_filtered_levels),
        .m_changed_mask    (m_changed_mask),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic deb_result_t debounce_step(mcpd_pkg::time_t now,
                                                  mcpd_pkg::level_vec_t raw);
        deb_result_t          res;
        mcpd_pkg::level_vec_t prior;
        mcpd_pkg::time_t      elapsed;
        prior = deb_level;
        for (int ch = 0; ch < mcpd_pkg::SLOTS; ch++) begin
            if (ch < NUM_CHANNELS && cfg_enable[ch]) begin
                if (raw[ch] != seen_raw[ch]) begin
                    seen_raw[ch] = raw[ch];
                    since_ms[ch] = now;
                end
                elapsed = now - since_ms[ch];
                if (raw[ch] != deb_level[ch] && elapsed >= cfg_filter[ch]) begin
                    deb_level[ch] = raw[ch];
                end
            end else begin
                seen_raw[ch]  = 1'b0;
                deb_level[ch] = 1'b0;
                since_ms[ch]  = '0;
            end
        end
        res.levels  = deb_level;
        res.changed = deb_level ^ prior;
        return res;
    endfunction

    task automatic report(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("mismatch: %s", msg);
        end
    endtask

    task automatic cfg_write(mcpd_pkg::cfg_idx_t idx,
                             logic [mcpd_pkg::CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            mcpd_pkg::REG_ENABLE: begin
                cfg_enable = data[mcpd_pkg::SLOTS-1:0];
            end
            mcpd_pkg::REG_FILTER_TIME_0, mcpd_pkg::REG_FILTER_TIME_1,
            mcpd_pkg::REG_FILTER_TIME_2, mcpd_pkg::REG_FILTER_TIME_3: begin
                cfg_filter[idx - mcpd_pkg::REG_FILTER_TIME_0] = data;
            end
            default: begin
            end
        endcase
    endtask

    task automatic cfg_release();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_sample(mcpd_pkg::time_t now, mcpd_pkg::level_vec_t raw);
        sample_t smp;
        smp.now = now;
        smp.raw = raw;
        samples_todo.insert(samples_todo.size(), smp);
    endtask

    // Waits until every request has gone out and every result has come back.
    task automatic drain();
        do begin
            @(negedge aclk);
        end while (samples_todo.size() != 0 || s_valid || levels_due.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_pace(int s_max, int m_max);
        send_gap_max  = s_max;
        ready_gap_max = m_max;
    endtask

    function automatic int pick_gap_max();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 8;
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    task automatic random_config();
        logic [mcpd_pkg::CFG_DATA_W-1:0] ft;
        case ($urandom_range(0, 9))
            0: cfg_write(mcpd_pkg::REG_ENABLE, '0);
            1, 2, 3, 4: cfg_write(mcpd_pkg::REG_ENABLE, {mcpd_pkg::CFG_DATA_W{1'b1}});
            default: cfg_write(mcpd_pkg::REG_ENABLE, $urandom());
        endcase
        for (int ch = 0; ch < mcpd_pkg::SLOTS; ch++) begin
            case ($urandom_range(0, 19))
                0, 1, 2: ft = '0;
                3, 4: ft = '1;
                5, 6, 7: ft = $urandom();
                default: ft = $urandom_range(1, 20);
            endcase
            cfg_write(mcpd_pkg::cfg_idx_t'(mcpd_pkg::REG_FILTER_TIME_0 + ch), ft);
        end
        if ($urandom_range(0, 3) == 0) begin
            cfg_write(mcpd_pkg::cfg_idx_t'($urandom_range(mcpd_pkg::REG_FILTER_TIME_3 + 1,
                                                          2**mcpd_pkg::CFG_IDX_W - 1)),
                      $urandom());
        end
        cfg_release();
    endtask

    // Slowly advancing time with occasional bounces, plus rare jumps in time
    // and rare scrambled levels.
    task automatic random_phase(int count);
        mcpd_pkg::time_t      t;
        mcpd_pkg::level_vec_t r;
        if ($urandom_range(0, 3) == 0) begin
            t = 32'hFFFF_FFFF - $urandom_range(0, 200);
        end else begin
            t = $urandom();
        end
        r = $urandom_range(0, 15);
        repeat (count) begin
            case ($urandom_range(0, 19))
                0: t = $urandom();
                1: r = $urandom_range(0, 15);
                default: begin
                    t += $urandom_range(0, 6);
                    if ($urandom_range(0, 3) == 0) begin
                        r ^= mcpd_pkg::level_vec_t'(1 << $urandom_range(0,
                                                        mcpd_pkg::SLOTS - 1));
                    end
                end
            endcase
            push_sample(t, r);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                predicted = debounce_step(s_now_ms, s_raw_levels);
                levels_due.insert(levels_due.size(), predicted);
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (samples_todo.size() != 0) begin
                    next_sample = samples_todo.pop_front();
                    s_valid      <= 1'b1;
                    s_now_ms     <= next_sample.now;
                    s_raw_levels <= next_sample.raw;
                    send_gap = $urandom_range(0, send_gap_max);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            ready_gap = 0;
        end else begin
            next_ready = 1'b1;
            if (m_valid && m_ready) begin
                if (levels_due.size() == 0) begin
                    report($sformatf("result with no request pending: levels %h mask %h",
                                     m_filtered_levels, m_changed_mask));
                end else begin
                    want = levels_due.pop_front();
                    if (m_filtered_levels !== want.levels) begin
                        report($sformatf("filtered_levels expected %h, got %h",
                                         want.levels, m_filtered_levels));
                    end
                    if (m_changed_mask !== want.changed) begin
                        report($sformatf("changed_mask expected %h, got %h",
                                         want.changed, m_changed_mask));
                    end
                end
                ready_gap = $urandom_range(0, ready_gap_max);
            end
            if (ready_gap > 0) begin
                ready_gap--;
                next_ready = 1'b0;
            end
            m_ready <= next_ready;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // All channels disabled after reset.
        push_sample(32'h0, 4'hF);
        push_sample(32'hFFFF_FFFF, 4'hA);
        drain();

        cfg_write(mcpd_pkg::REG_ENABLE, 32'hF);
        cfg_write(mcpd_pkg::REG_FILTER_TIME_0, 32'd0);
        cfg_write(mcpd_pkg::REG_FILTER_TIME_1, 32'd10);
        cfg_write(mcpd_pkg::REG_FILTER_TIME_2, 32'hFFFF_FFFF);
        cfg_write(mcpd_pkg::REG_FILTER_TIME_3, 32'd5);
        for (int k = mcpd_pkg::REG_FILTER_TIME_3 + 1; k < 2**mcpd_pkg::CFG_IDX_W; k++) begin
            cfg_write(mcpd_pkg::cfg_idx_t'(k), 32'hFFFF_FFFF);
        end
        cfg_release();

        // Zero filter time follows at once; the others settle after their times.
        push_sample(32'd100, 4'hF);
        push_sample(32'd105, 4'hF);
        push_sample(32'd110, 4'hF);
        push_sample(32'd111, 4'h0);
        push_sample(32'd112, 4'hF);
        // The maximum filter time is reached only one step short of a full wrap.
        push_sample(32'd110, 4'hF);
        push_sample(32'd111, 4'hF);
        // Elapsed time across the timestamp wrap.
        push_sample(32'hFFFF_FFFC, 4'h0);
        push_sample(32'd0, 4'h0);
        push_sample(32'd1, 4'h0);
        push_sample(32'd6, 4'h0);
        drain();

        // Disabling a channel that is high clears it and flags the change.
        cfg_write(mcpd_pkg::REG_ENABLE, 32'h0);
        cfg_release();
        push_sample(32'd7, 4'hF);
        drain();

        // Re-enable from a fresh state and shorten one filter time.
        cfg_write(mcpd_pkg::REG_ENABLE, 32'hF);
        cfg_write(mcpd_pkg::REG_FILTER_TIME_1, 32'd3);
        cfg_release();
        push_sample(32'd8, 4'hF);
        push_sample(32'd11, 4'hF);
        push_sample(32'd13, 4'hF);
        push_sample(32'hFFFF_FFFF, 4'h5);
        push_sample(32'hFFFF_FFFF, 4'hA);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_config();
            if (p == 0) begin
                set_pace(0, 0);
            end else begin
                set_pace(pick_gap_max(), pick_gap_max());
            end
            random_phase(PHASE_ITEMS);
            drain();
        end

        repeat (8) @(posedge aclk);
        if (levels_due.size() != 0) begin
            report($sformatf("%0d results never arrived", levels_due.size()));
        end
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> files.f
src/mcpd_pkg.sv
src/mcpd_cfg.sv
src/mcpd_channel.sv
src/multi_channel_pin_debouncer.sv
tb/sv/tb_multi_channel_pin_debouncer.sv
